### sv/ecgphr_pkg.sv
// Package for the ECG peak and heart rate unit: widths, register map and shared types.
// It has no dependencies; every other file of the unit imports it.
package ecgphr_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int INDEX_BITS  = 16;
    localparam int THR_BITS    = 12;
    localparam int RATE_BITS   = 12;
    localparam int COUNT_BITS  = 15;
    localparam int BPM_BITS    = 25;
    localparam int FRAC_BITS   = 8;
    localparam int DATA_BITS   = 32;
    localparam int ADDR_BITS   = 3;

    localparam int CMP_BITS    = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
    localparam int SEC_PER_MIN = 60;
    localparam int MIN_BITS    = $clog2(SEC_PER_MIN + 1);
    localparam int PROD_BITS   = RATE_BITS + COUNT_BITS;
    localparam int SCALED_BITS = PROD_BITS + MIN_BITS;
    localparam int NUM_BITS    = SCALED_BITS + FRAC_BITS;
    localparam int STEP_BITS   = $clog2(NUM_BITS);

    localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [BPM_BITS-1:0]   BPM_MAX   = {BPM_BITS{1'b1}};

    // Register select bit of the byte address: threshold at 0, sample rate at 4.
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_RATE      = 1'b1;

    localparam logic [THR_BITS-1:0]  THR_RESET  = THR_BITS'(126);
    localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(20);

    typedef logic [INDEX_BITS-1:0] index_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        count_t peak_count;
        index_t first_peak;
        index_t last_peak;
        logic   overflow;
    } rec_summary_t;

endpackage

### sv/ecgphr_cfg_regs.sv
// Configuration registers of the ECG peak and heart rate unit behind an APB-style port.
// Depends on ecgphr_pkg.
module ecgphr_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ecgphr_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [ecgphr_pkg::DATA_BITS-1:0]    pwdata,
    output logic [ecgphr_pkg::DATA_BITS-1:0]    prdata,
    output logic                                pready,
    output logic signed [ecgphr_pkg::THR_BITS-1:0] peak_threshold,
    output logic [ecgphr_pkg::RATE_BITS-1:0]    sample_rate_hz
);
    import ecgphr_pkg::*;

    logic [THR_BITS-1:0]  thr_reg;
    logic [RATE_BITS-1:0] rate_reg;
    logic                 wr_en;
    logic                 reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            rate_reg <= RATE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_THRESHOLD: thr_reg  <= pwdata[THR_BITS-1:0];
                REG_RATE:      rate_reg <= pwdata[RATE_BITS-1:0];
                default:       thr_reg  <= thr_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_THRESHOLD: prdata = DATA_BITS'(thr_reg);
            REG_RATE:      prdata = DATA_BITS'(rate_reg);
            default:       prdata = '0;
        endcase
    end

    assign peak_threshold = $signed(thr_reg);
    assign sample_rate_hz = rate_reg;

endmodule

### sv/ecgphr_peak_track.sv
// Peak tracker: keeps the last two samples, the sample index and the peak statistics.
// Depends on ecgphr_pkg; hands a record summary to the rate divider on the last word.
module ecgphr_peak_track (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   accept,
    input  logic signed [ecgphr_pkg::SAMPLE_BITS-1:0] ecg_sample,
    input  logic                                   record_end,
    input  logic signed [ecgphr_pkg::THR_BITS-1:0] peak_threshold,
    output ecgphr_pkg::rec_summary_t               summary
);
    import ecgphr_pkg::*;

    localparam logic [1:0] FILL_FULL = 2'd2;

    logic signed [SAMPLE_BITS-1:0] older_reg;
    logic signed [SAMPLE_BITS-1:0] newer_reg;
    logic [1:0]                    fill_reg;
    index_t                        index_reg;
    count_t                        count_reg;
    index_t                        first_reg;
    index_t                        last_reg;
    logic                          ovf_reg;

    logic signed [CMP_BITS-1:0] older_ext;
    logic signed [CMP_BITS-1:0] newer_ext;
    logic signed [CMP_BITS-1:0] sample_ext;
    logic signed [CMP_BITS-1:0] thr_ext;
    logic                       is_peak;
    index_t                     peak_index;
    rec_summary_t               summary_next;

    always_comb
    begin
        older_ext  = CMP_BITS'(older_reg);
        newer_ext  = CMP_BITS'(newer_reg);
        sample_ext = CMP_BITS'(ecg_sample);
        thr_ext    = CMP_BITS'(peak_threshold);
        is_peak    = (fill_reg == FILL_FULL) && (newer_ext > older_ext) &&
                     (newer_ext > sample_ext) && (newer_ext > thr_ext);
        peak_index = index_reg - INDEX_BITS'(1);

        summary_next.peak_count = (is_peak && count_reg != COUNT_MAX) ?
                                  count_reg + COUNT_BITS'(1) : count_reg;
        summary_next.first_peak = (is_peak && count_reg == '0) ? peak_index : first_reg;
        summary_next.last_peak  = is_peak ? peak_index : last_reg;
        summary_next.overflow   = ovf_reg || (index_reg == INDEX_MAX);
    end

    assign summary = summary_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg <= '0;
            newer_reg <= '0;
            fill_reg  <= '0;
            index_reg <= '0;
            count_reg <= '0;
            first_reg <= '0;
            last_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (record_end)
            begin
                older_reg <= '0;
                newer_reg <= '0;
                fill_reg  <= '0;
                index_reg <= '0;
                count_reg <= '0;
                first_reg <= '0;
                last_reg  <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                older_reg <= newer_reg;
                newer_reg <= ecg_sample;
                if (fill_reg != FILL_FULL)
                begin
                    fill_reg <= fill_reg + 2'd1;
                end
                if (index_reg != INDEX_MAX)
                begin
                    index_reg <= index_reg + INDEX_BITS'(1);
                end
                count_reg <= summary_next.peak_count;
                first_reg <= summary_next.first_peak;
                last_reg  <= summary_next.last_peak;
                ovf_reg   <= summary_next.overflow;
            end
        end
    end

endmodule

### sv/ecgphr_rate_div.sv
// Heart rate engine: forms 60 * rate * (count - 1) * 256 and divides it by the peak span
// with a bit-serial restoring divider, then holds the result word. Depends on ecgphr_pkg.
module ecgphr_rate_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  ecgphr_pkg::rec_summary_t            summary,
    input  logic [ecgphr_pkg::RATE_BITS-1:0]    sample_rate_hz,
    output logic                                busy,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ecgphr_pkg::BPM_BITS-1:0]     bpm_q8,
    output logic [ecgphr_pkg::COUNT_BITS-1:0]   peaks_found,
    output logic                                rate_valid,
    output logic                                index_overflow
);
    import ecgphr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_SCALE,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t                 state_reg;
    logic [RATE_BITS-1:0]   rate_reg;
    count_t                 count_reg;
    index_t                 span_reg;
    logic                   valid_reg;
    logic                   ovf_reg;
    logic [PROD_BITS-1:0]   prod_reg;
    logic [NUM_BITS-1:0]    quot_reg;
    index_t                 rem_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic                   out_valid_reg;
    logic [BPM_BITS-1:0]    bpm_reg;
    count_t                 peaks_reg;
    logic                   rate_valid_reg;
    logic                   ovf_out_reg;

    logic                   rec_valid;
    logic [INDEX_BITS:0]    trial;
    logic                   fits;
    index_t                 rem_next;
    logic [SCALED_BITS-1:0] scaled;
    logic [BPM_BITS-1:0]    bpm_next;
    logic                   slot_free;
    logic                   load_out;
    logic                   out_valid_next;

    always_comb
    begin
        rec_valid = (summary.peak_count >= COUNT_BITS'(2)) &&
                    (summary.last_peak > summary.first_peak);
        trial     = {rem_reg, quot_reg[NUM_BITS-1]};
        fits      = trial >= {1'b0, span_reg};
        rem_next  = fits ? INDEX_BITS'(trial - {1'b0, span_reg}) : trial[INDEX_BITS-1:0];
        scaled    = SCALED_BITS'(prod_reg) * SCALED_BITS'(SEC_PER_MIN);
        bpm_next  = (quot_reg[NUM_BITS-1:BPM_BITS] != '0) ? BPM_MAX
                                                          : quot_reg[BPM_BITS-1:0];
        slot_free = !out_valid_reg || !out_stall;
        load_out  = (state_reg == ST_HOLD) && slot_free;
        out_valid_next = load_out || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            rate_reg       <= '0;
            count_reg      <= '0;
            span_reg       <= '0;
            valid_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
            prod_reg       <= '0;
            quot_reg       <= '0;
            rem_reg        <= '0;
            step_reg       <= '0;
            bpm_reg        <= '0;
            peaks_reg      <= '0;
            rate_valid_reg <= 1'b0;
            ovf_out_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        rate_reg  <= sample_rate_hz;
                        count_reg <= summary.peak_count;
                        span_reg  <= summary.last_peak - summary.first_peak;
                        valid_reg <= rec_valid;
                        ovf_reg   <= summary.overflow;
                        quot_reg  <= '0;
                        state_reg <= rec_valid ? ST_MULT : ST_HOLD;
                    end
                end
                ST_MULT:
                begin
                    prod_reg  <= PROD_BITS'(rate_reg) *
                                 PROD_BITS'(count_reg - COUNT_BITS'(1));
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    quot_reg  <= {scaled, {FRAC_BITS{1'b0}}};
                    rem_reg   <= '0;
                    step_reg  <= STEP_BITS'(NUM_BITS - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg  <= rem_next;
                    quot_reg <= {quot_reg[NUM_BITS-2:0], fits};
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_HOLD;
                    end
                    else
                    begin
                        step_reg <= step_reg - STEP_BITS'(1);
                    end
                end
                ST_HOLD:
                begin
                    if (load_out)
                    begin
                        bpm_reg        <= bpm_next;
                        peaks_reg      <= count_reg;
                        rate_valid_reg <= valid_reg;
                        ovf_out_reg    <= ovf_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign bpm_q8         = bpm_reg;
    assign peaks_found    = peaks_reg;
    assign rate_valid     = rate_valid_reg;
    assign index_overflow = ovf_out_reg;

endmodule

### sv/ecg_peak_heart_rate_unit.sv
// Top level of the ECG R peak detector and heart rate unit.
// Depends on ecgphr_pkg, ecgphr_cfg_regs, ecgphr_peak_track and ecgphr_rate_div.
//
//   Channel   Handshake                 Payload
//   input     in_valid / in_stall       ecg_sample, record_end
//   output    out_valid / out_stall     bpm_q8, peaks_found, rate_valid, index_overflow
//   config    psel, penable, pready     paddr, pwdata, pwrite, prdata
//
// A sample word is taken whenever in_valid is high and the rate engine is idle. The last word
// of a record starts the rate engine, and input stalls through multiply, scale and a 41-step
// serial divide, or only through the hold state when no rate can be formed.
// Reset clears all record state and loads the register reset values.
// Sample words keep flowing while a result waits under out_stall, but the next record's
// last word keeps the input stalled until that earlier result has been taken.
module ecg_peak_heart_rate_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ecgphr_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [ecgphr_pkg::DATA_BITS-1:0]       pwdata,
    output logic [ecgphr_pkg::DATA_BITS-1:0]       prdata,
    output logic                                   pready,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [ecgphr_pkg::SAMPLE_BITS-1:0] ecg_sample,
    input  logic                                   record_end,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [ecgphr_pkg::BPM_BITS-1:0]        bpm_q8,
    output logic [ecgphr_pkg::COUNT_BITS-1:0]      peaks_found,
    output logic                                   rate_valid,
    output logic                                   index_overflow
);
    import ecgphr_pkg::*;

    logic signed [THR_BITS-1:0] peak_threshold;
    logic [RATE_BITS-1:0]       sample_rate_hz;
    logic                       accept;
    logic                       busy;
    rec_summary_t               summary;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    ecgphr_cfg_regs u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .peak_threshold (peak_threshold),
        .sample_rate_hz (sample_rate_hz)
    );

    ecgphr_peak_track u_track (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .ecg_sample     (ecg_sample),
        .record_end     (record_end),
        .peak_threshold (peak_threshold),
        .summary        (summary)
    );

    ecgphr_rate_div u_div (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (accept && record_end),
        .summary        (summary),
        .sample_rate_hz (sample_rate_hz),
        .busy           (busy),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .bpm_q8         (bpm_q8),
        .peaks_found    (peaks_found),
        .rate_valid     (rate_valid),
        .index_overflow (index_overflow)
    );

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Testbench for ecg_peak_heart_rate_unit. It sends ECG sample records and register writes,
// predicts each heart rate word with its own model of the unit or takes a typed one, and compares every field.
// Depends on ecgphr_pkg and the RTL of the unit.
module testbench;
    import ecgphr_pkg::*;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic [BPM_BITS-1:0]   bpm;
        logic [COUNT_BITS-1:0] peaks;
        logic                  valid;
        logic                  ovf;
    } rate_word_t;

    typedef struct packed {
        sample_t    sample;
        logic       last;
        logic       typed;
        rate_word_t res;
    } probe_t;

    localparam int PROBE_COUNT = 24;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_BITS-1:0]   paddr = '0;
    logic [DATA_BITS-1:0]   pwdata = '0;
    logic [DATA_BITS-1:0]   prdata;
    logic                   pready;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    sample_t                ecg_sample = '0;
    logic                   record_end = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [BPM_BITS-1:0]    bpm_q8;
    logic [COUNT_BITS-1:0]  peaks_found;
    logic                   rate_valid;
    logic                   index_overflow;

    logic signed [THR_BITS-1:0] thr_setting;
    logic [RATE_BITS-1:0]       rate_setting;
    sample_t                    hold_old;
    sample_t                    hold_new;
    logic [1:0]                 hold_fill;
    index_t                     next_index;
    count_t                     peak_total;
    index_t                     first_peak_at;
    index_t                     last_peak_at;
    logic                       index_sat;

    rate_word_t pending_rates[$];
    probe_t     probes [PROBE_COUNT];
    int         error_count = 0;
    int         idle_pct = 27;

    ecg_peak_heart_rate_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .ecg_sample     (ecg_sample),
        .record_end     (record_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .bpm_q8         (bpm_q8),
        .peaks_found    (peaks_found),
        .rate_valid     (rate_valid),
        .index_overflow (index_overflow)
    );

    always #1 clk = ~clk;

    initial
    begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void clear_track();
        hold_old      = '0;
        hold_new      = '0;
        hold_fill     = '0;
        next_index    = '0;
        peak_total    = '0;
        first_peak_at = '0;
        last_peak_at  = '0;
        index_sat     = 1'b0;
    endfunction

    function automatic bit track_sample(input sample_t s, input logic last,
                                        output rate_word_t r);
        logic [63:0] num;
        logic [63:0] span;
        logic [63:0] quo;
        index_t      cur;
        cur = next_index;
        r = '0;
        if (hold_fill == 2'd2 && hold_new > hold_old && hold_new > s &&
            hold_new > thr_setting)
        begin
            if (peak_total == '0)
                first_peak_at = cur - 1'b1;
            last_peak_at = cur - 1'b1;
            if (peak_total != COUNT_MAX)
                peak_total = peak_total + 1'b1;
        end
        hold_old = hold_new;
        hold_new = s;
        if (hold_fill != 2'd2)
            hold_fill = hold_fill + 1'b1;
        if (cur == INDEX_MAX)
            index_sat = 1'b1;
        else
            next_index = cur + 1'b1;
        if (!last)
            return 1'b0;
        if (peak_total >= 2 && last_peak_at > first_peak_at)
        begin
            span = 64'(last_peak_at) - 64'(first_peak_at);
            num  = 64'd60 * 64'(rate_setting) * (64'(peak_total) - 64'd1) * 64'd256;
            quo  = num / span;
            r.bpm   = (quo > 64'(BPM_MAX)) ? BPM_MAX : quo[BPM_BITS-1:0];
            r.valid = 1'b1;
        end
        r.peaks = peak_total;
        r.ovf   = index_sat;
        clear_track();
        return 1'b1;
    endfunction

    function automatic sample_t pick_sample(input int style);
        int t;
        int v;
        t = thr_setting;
        if (style == 0 || t >= 2047)
            v = $urandom_range(0, 4095) - 2048;
        else if ($urandom_range(0, 5) == 0)
            v = t + 1 + $urandom_range(0, 2046 - t);
        else
            v = -2048 + $urandom_range(0, t + 2048);
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic probe_t make_probe(input int s, input logic last, input logic typed,
                                          input int bpm, input int peaks, input logic valid,
                                          input logic ovf);
        probe_t p;
        p.sample    = s[SAMPLE_BITS-1:0];
        p.last      = last;
        p.typed     = typed;
        p.res.bpm   = bpm[BPM_BITS-1:0];
        p.res.peaks = peaks[COUNT_BITS-1:0];
        p.res.valid = valid;
        p.res.ovf   = ovf;
        return p;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        rate_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rates.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none actual bpm_q8=%0d",
                         $time, bpm_q8);
                error_count++;
            end
            else
            begin
                want = pending_rates.pop_front();
                compare_field("bpm_q8", want.bpm, bpm_q8);
                compare_field("peaks_found", want.peaks, peaks_found);
                compare_field("rate_valid", want.valid, rate_valid);
                compare_field("index_overflow", want.ovf, index_overflow);
            end
        end
        out_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    task automatic write_reg(input logic sel, input logic [DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_THRESHOLD)
            thr_setting = data[THR_BITS-1:0];
        else
            rate_setting = data[RATE_BITS-1:0];
        @(posedge clk);
    endtask

    task automatic apply_setting(input int thr, input int rate);
        write_reg(REG_THRESHOLD, ($urandom & 32'hFFFF_F000) | (thr & 32'hFFF));
        write_reg(REG_RATE, ($urandom & 32'hFFFF_F000) | (rate & 32'hFFF));
    endtask

    task automatic send_sample(input sample_t s, input logic last, input logic typed,
                               input rate_word_t typed_res);
        rate_word_t r;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        ecg_sample <= s;
        record_end <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (track_sample(s, last, r))
            pending_rates.push_back(typed ? typed_res : r);
    endtask

    task automatic send_record(input int len, input int style);
        for (int i = 0; i < len; i++)
            send_sample(pick_sample(style), i == len - 1, 1'b0, '0);
    endtask

    task automatic send_long(input int start, input int len);
        sample_t s;
        for (int i = 0; i < len; i++)
        begin
            s = (i >= start && (i - start) % 2 == 0) ? 12'sd1000 : 12'sd0;
            send_sample(s, i == len - 1, 1'b0, '0);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_rates.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    initial
    begin
        int ph_items;
        int len;
        int style;
        thr_setting  = THR_RESET;
        rate_setting = RATE_RESET;
        clear_track();
        probes[0]  = make_probe(0, 1, 1, 0, 0, 0, 0);
        probes[1]  = make_probe(2047, 0, 0, 0, 0, 0, 0);
        probes[2]  = make_probe(2047, 1, 1, 0, 0, 0, 0);
        probes[3]  = make_probe(-2048, 0, 0, 0, 0, 0, 0);
        probes[4]  = make_probe(2047, 0, 0, 0, 0, 0, 0);
        probes[5]  = make_probe(-2048, 0, 0, 0, 0, 0, 0);
        probes[6]  = make_probe(2047, 1, 1, 0, 1, 0, 0);
        probes[7]  = make_probe(0, 0, 0, 0, 0, 0, 0);
        probes[8]  = make_probe(500, 0, 0, 0, 0, 0, 0);
        probes[9]  = make_probe(0, 0, 0, 0, 0, 0, 0);
        probes[10] = make_probe(500, 0, 0, 0, 0, 0, 0);
        probes[11] = make_probe(0, 1, 1, 153600, 2, 1, 0);
        probes[12] = make_probe(300, 0, 0, 0, 0, 0, 0);
        probes[13] = make_probe(300, 0, 0, 0, 0, 0, 0);
        probes[14] = make_probe(0, 0, 0, 0, 0, 0, 0);
        probes[15] = make_probe(127, 0, 0, 0, 0, 0, 0);
        probes[16] = make_probe(0, 0, 0, 0, 0, 0, 0);
        probes[17] = make_probe(126, 0, 0, 0, 0, 0, 0);
        probes[18] = make_probe(0, 1, 0, 0, 0, 0, 0);
        probes[19] = make_probe(-1366, 0, 0, 0, 0, 0, 0);
        probes[20] = make_probe(1365, 0, 0, 0, 0, 0, 0);
        probes[21] = make_probe(-1366, 0, 0, 0, 0, 0, 0);
        probes[22] = make_probe(1365, 0, 0, 0, 0, 0, 0);
        probes[23] = make_probe(-2048, 1, 0, 0, 0, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PROBE_COUNT; i++)
            send_sample(probes[i].sample, probes[i].last, probes[i].typed, probes[i].res);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: apply_setting(-2048, 4095);
                1: apply_setting(2047, 1);
                2: apply_setting(0, 0);
                3: apply_setting(126, 20);
                default: apply_setting($urandom_range(0, 4095) - 2048, $urandom_range(1, 4095));
            endcase
            idle_pct = (ph == 3) ? 0 : 27;
            ph_items = 0;
            while (ph_items < 175)
            begin
                case ($urandom_range(0, 9))
                    0: len = $urandom_range(1, 2);
                    1, 2: len = $urandom_range(31, 120);
                    default: len = $urandom_range(3, 30);
                endcase
                style = ($urandom_range(0, 3) == 0) ? 0 : 1;
                send_record(len, style);
                ph_items += len;
                if ($urandom_range(0, 19) == 0)
                    drain();
            end
            drain();
        end

        // Long records drive the sample index and the peak count into saturation.
        apply_setting(126, 4095);
        idle_pct = 0;
        send_long(1, 131100);
        idle_pct = 27;
        send_long(65532, 65560);
        send_long(65534, 65560);
        drain();

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
